/* hdl/kfr_pkg.sv */
// Shared types, codes and a helper function for the Kermit frame receiver.
// No dependencies; every other file of the block refers to it by scoped names.
package kfr_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes.
    localparam logic CFG_START_MARK     = 1'b0;
    localparam logic CFG_CONTROL_PREFIX = 1'b1;

    localparam logic [7:0] START_MARK_RESET     = 8'd1;
    localparam logic [7:0] CONTROL_PREFIX_RESET = 8'd35;

    // Result kinds.
    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_GOOD      = 3'd1;
    localparam logic [2:0] KIND_HDR_BAD   = 3'd2;
    localparam logic [2:0] KIND_BLOCK_BAD = 3'd3;
    localparam logic [2:0] KIND_BAD_LEN   = 3'd4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_SEQ,
        PH_TYPE,
        PH_XL1,
        PH_XL2,
        PH_HCHK,
        PH_DATA
    } phase_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic [7:0] sequence_res;
    } result_t;

    // Type-1 check: fold the top two bits into the low six, then make it printable.
    function automatic logic [7:0] fold_check(input logic [7:0] s);
        logic [5:0] t;
        t = s[5:0] + {4'b0000, s[7:6]};
        return {2'b00, t} + 8'd32;
    endfunction

endpackage

/* hdl/kfr_front.sv */
// Front end of the Kermit frame receiver: frame parser, prefix decoder and checksum.
// Depends on kfr_pkg. Produces at most one result word per accepted byte.
module kfr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [7:0]      cfg_data,
    input  logic            byte_valid,
    input  logic [7:0]      rx_byte,
    output logic            res_valid,
    output kfr_pkg::result_t res
);

    kfr_pkg::phase_t phase_reg, phase_next;
    logic [14:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  sum_reg, sum_next;
    logic        esc_reg, esc_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  xl1_reg, xl1_next;
    logic [7:0]  start_mark_reg;
    logic [7:0]  prefix_reg;

    logic        emit;
    logic [2:0]  emit_kind;
    logic [7:0]  emit_data;

    logic signed [9:0]  len_hi;
    logic signed [9:0]  len_lo;
    logic signed [15:0] ext_len;
    logic [7:0]         check_val;
    logic [7:0]         sum_add;

    assign len_hi    = $signed({2'b00, xl1_reg}) - 10'sd32;
    assign len_lo    = $signed({2'b00, rx_byte}) - 10'sd32;
    assign ext_len   = 16'(len_hi) * 16'sd95 + 16'(len_lo);
    assign check_val = kfr_pkg::fold_check(sum_reg);
    assign sum_add   = sum_reg + rx_byte;

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        esc_next        = esc_reg;
        type_next       = type_reg;
        seq_next        = seq_reg;
        xl1_next        = xl1_reg;
        emit            = 1'b0;
        emit_kind       = kfr_pkg::KIND_DATA;
        emit_data       = 8'd0;
        if (byte_valid)
        begin
            case (phase_reg)
                kfr_pkg::PH_HUNT:
                begin
                    if (rx_byte == start_mark_reg)
                    begin
                        phase_next      = kfr_pkg::PH_LEN;
                        sum_next        = 8'd0;
                        esc_next        = 1'b0;
                        bytes_left_next = 15'd0;
                    end
                end
                kfr_pkg::PH_LEN:
                begin
                    sum_next        = sum_add;
                    bytes_left_next = {7'd0, rx_byte};
                    phase_next      = kfr_pkg::PH_SEQ;
                end
                kfr_pkg::PH_SEQ:
                begin
                    sum_next   = sum_add;
                    seq_next   = rx_byte - 8'd32;
                    phase_next = kfr_pkg::PH_TYPE;
                end
                kfr_pkg::PH_TYPE:
                begin
                    sum_next  = sum_add;
                    type_next = rx_byte;
                    if (bytes_left_reg == 15'd32)
                    begin
                        phase_next = kfr_pkg::PH_XL1;
                    end
                    else if (bytes_left_reg >= 15'd35)
                    begin
                        bytes_left_next = bytes_left_reg - 15'd34;
                        phase_next      = kfr_pkg::PH_DATA;
                    end
                    else
                    begin
                        phase_next = kfr_pkg::PH_HUNT;
                        emit       = 1'b1;
                        emit_kind  = kfr_pkg::KIND_BAD_LEN;
                    end
                end
                kfr_pkg::PH_XL1:
                begin
                    sum_next   = sum_add;
                    xl1_next   = rx_byte;
                    phase_next = kfr_pkg::PH_XL2;
                end
                kfr_pkg::PH_XL2:
                begin
                    sum_next        = sum_add;
                    bytes_left_next = (ext_len >= 16'sd1) ? ext_len[14:0] : 15'd0;
                    phase_next      = kfr_pkg::PH_HCHK;
                end
                kfr_pkg::PH_HCHK:
                begin
                    if (rx_byte != check_val)
                    begin
                        phase_next = kfr_pkg::PH_HUNT;
                        emit       = 1'b1;
                        emit_kind  = kfr_pkg::KIND_HDR_BAD;
                    end
                    else
                    begin
                        // The header check is counted in the block sum.
                        sum_next = sum_add;
                        if (bytes_left_reg == 15'd0)
                        begin
                            phase_next = kfr_pkg::PH_HUNT;
                            emit       = 1'b1;
                            emit_kind  = kfr_pkg::KIND_BAD_LEN;
                        end
                        else
                        begin
                            phase_next = kfr_pkg::PH_DATA;
                        end
                    end
                end
                default:
                begin
                    if (bytes_left_reg <= 15'd1)
                    begin
                        phase_next = kfr_pkg::PH_HUNT;
                        emit       = 1'b1;
                        emit_kind  = (rx_byte == check_val) ? kfr_pkg::KIND_GOOD
                                                            : kfr_pkg::KIND_BLOCK_BAD;
                    end
                    else
                    begin
                        bytes_left_next = bytes_left_reg - 15'd1;
                        sum_next        = sum_add;
                        if (esc_reg)
                        begin
                            esc_next  = 1'b0;
                            emit      = 1'b1;
                            emit_data = (rx_byte == prefix_reg) ? prefix_reg
                                                                : (rx_byte ^ 8'h40);
                        end
                        else if (rx_byte == prefix_reg)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            emit      = 1'b1;
                            emit_data = rx_byte;
                        end
                    end
                end
            endcase
        end
    end

    // Status words carry the frame fields as they stand after this byte.
    always_comb
    begin
        res_valid        = emit;
        res.kind         = emit_kind;
        res.data_byte    = emit_data;
        res.frame_type   = type_next;
        res.sequence_res = seq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= kfr_pkg::PH_HUNT;
            bytes_left_reg <= 15'd0;
            sum_reg        <= 8'd0;
            esc_reg        <= 1'b0;
            type_reg       <= 8'd0;
            seq_reg        <= 8'd0;
            xl1_reg        <= 8'd0;
            start_mark_reg <= kfr_pkg::START_MARK_RESET;
            prefix_reg     <= kfr_pkg::CONTROL_PREFIX_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
            esc_reg        <= esc_next;
            type_reg       <= type_next;
            seq_reg        <= seq_next;
            xl1_reg        <= xl1_next;
            if (cfg_we && cfg_index == kfr_pkg::CFG_START_MARK)
            begin
                start_mark_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == kfr_pkg::CFG_CONTROL_PREFIX)
            begin
                prefix_reg <= cfg_data;
            end
        end
    end

endmodule

/* hdl/kfr_queue.sv */
// Result queue between the frame parser and the result port.
// Depends on kfr_pkg for the result word type.
module kfr_queue
#(
    parameter int DEPTH = kfr_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  kfr_pkg::result_t  wr_data,
    input  logic              rd_en,
    output kfr_pkg::result_t  rd_data,
    output logic              full,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kfr_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/kermit_frame_receiver.sv */
// Kermit frame receiver, type-1 block check. Top level over kfr_front and kfr_queue.
// Output path: a word caused by a byte is registered in the result queue as the byte is taken.
// Throughput: one byte per cycle while full is low, as the parser updates on each taken byte; full rises only
// when the result queue (QUEUE_DEPTH words) is full.
// Reset: asynchronous, active low; registers go to their defaults, the parser hunts for
// the start mark and the queue is empty.
module kermit_frame_receiver
#(
    parameter int QUEUE_DEPTH = kfr_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] kind,
    output logic [7:0] data_byte,
    output logic [7:0] frame_type,
    output logic [7:0] sequence_res
);

    logic             accept;
    logic             res_valid;
    kfr_pkg::result_t res;
    kfr_pkg::result_t head;

    assign accept = push && !full;

    kfr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_valid (accept),
        .rx_byte    (rx_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    kfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && res_valid),
        .wr_data (res),
        .rd_en   (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    assign kind         = head.kind;
    assign data_byte    = head.data_byte;
    assign frame_type   = head.frame_type;
    assign sequence_res = head.sequence_res;

endmodule

/* hdl/kfr_checker.sv */
// Port-level checks for the Kermit frame receiver, bound to the top level.
// Depends on kfr_pkg for the result kind codes.
module kfr_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [2:0] kind,
    input logic [7:0] data_byte
);

    // A full queue always has a word to offer.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full and empty both high");

    // A word cannot appear without a byte having been taken.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !push) |=> empty)
        else $error("result appeared with no byte accepted");

    // Taking a word with no byte coming in frees a slot.
    a_pop_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !push) |=> !full)
        else $error("queue still full after a pop");

    // Status words carry a zero data byte.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != kfr_pkg::KIND_DATA) |-> (data_byte == 8'd0))
        else $error("status word with nonzero data byte");

    // A waiting word holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(data_byte)))
        else $error("waiting word changed");

endmodule

bind kermit_frame_receiver kfr_checker u_kfr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .kind      (kind),
    .data_byte (data_byte)
);
